### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of the clock while out of reset.
`define ASSERT_CHK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that one condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hdl/abcp_pkg.sv
package abcp_pkg;

    localparam int MAX_BRACKETS_DEF = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [3:0] DEFAULT_DIVIDER = 4'd7;
    localparam logic [3:0] RESET_DIVIDER = 4'd7;
    localparam logic [31:0] FRAME_NONE = 32'hFFFF_FFFF;

    localparam logic [2:0] REQ_PC = 3'd0;
    localparam logic [2:0] REQ_FRAME = 3'd1;
    localparam logic [2:0] REQ_REBASE = 3'd2;
    localparam logic [2:0] REQ_ADD = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [1:0] CFG_DIVIDER = 2'd0;
    localparam logic [1:0] CFG_LOG = 2'd1;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_TOTAL = 2'd1;
    localparam logic [1:0] KIND_BRACKET = 2'd2;

    typedef enum logic [2:0] {
        OP_PC,
        OP_FRAME,
        OP_REBASE,
        OP_ADD,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [23:0] pc;
        logic [31:0] cycle;
        logic [31:0] frame;
        logic [23:0] saddr;
        logic [23:0] eaddr;
        logic [31:0] deduct;
    } item_t;

endpackage

### hdl/abcp_front.sv
`include "assert_macros.svh"

module abcp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           req_type,
    input  logic [23:0]          pc,
    input  logic [31:0]          cycle,
    input  logic [31:0]          frame_number,
    input  logic [23:0]          start_address,
    input  logic [23:0]          end_address,
    input  logic [31:0]          deduction,
    output logic                 q_valid,
    output abcp_pkg::item_t      q_item,
    input  logic                 q_pop
);

    abcp_pkg::item_t entry_reg [abcp_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            known;
    logic            push;
    abcp_pkg::item_t item;

    always_comb
    begin
        known = 1'b1;
        item.op = abcp_pkg::OP_PC;
        case (req_type)
            abcp_pkg::REQ_PC:     item.op = abcp_pkg::OP_PC;
            abcp_pkg::REQ_FRAME:  item.op = abcp_pkg::OP_FRAME;
            abcp_pkg::REQ_REBASE: item.op = abcp_pkg::OP_REBASE;
            abcp_pkg::REQ_ADD:    item.op = abcp_pkg::OP_ADD;
            abcp_pkg::REQ_CLEAR:  item.op = abcp_pkg::OP_CLEAR;
            default:              known = 1'b0;
        endcase
        item.pc = pc;
        item.cycle = cycle;
        item.frame = frame_number;
        item.saddr = start_address;
        item.eaddr = end_address;
        item.deduct = deduction;
    end

    assign in_stall = (cnt_reg == 2'(abcp_pkg::QUEUE_DEPTH));
    assign push = in_valid && !in_stall && known;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

    `ASSERT_CHK(a_no_overflow, clk, rst_n, !(push && cnt_reg == 2'(abcp_pkg::QUEUE_DEPTH)),
        "queue written while full")

endmodule

### hdl/abcp_back.sv
`include "assert_macros.svh"

module abcp_back
#(
    parameter int MAX_BRACKETS = abcp_pkg::MAX_BRACKETS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_data,
    input  logic                 q_valid,
    input  abcp_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           record_kind,
    output logic [31:0]          frame_out,
    output logic [2:0]           bracket_index,
    output logic [31:0]          cpu_cycles,
    output logic [31:0]          hit_count,
    output logic                 status,
    output logic                 last
);

    localparam int IDXW = (MAX_BRACKETS > 1) ? $clog2(MAX_BRACKETS) : 1;
    localparam int CW = $clog2(MAX_BRACKETS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t            state_reg;
    logic [23:0]       entry_addr_reg [MAX_BRACKETS];
    logic [23:0]       exit_addr_reg [MAX_BRACKETS];
    logic [31:0]       entry_cycle_reg [MAX_BRACKETS];
    logic [31:0]       accum_reg [MAX_BRACKETS];
    logic [31:0]       hits_reg [MAX_BRACKETS];
    logic [MAX_BRACKETS-1:0] active_reg;
    logic [CW-1:0]     count_reg;
    logic [31:0]       anchor_reg;
    logic              anchor_valid_reg;
    logic [31:0]       prev_frame_reg;
    logic [3:0]        divider_reg;
    logic              log_reg;

    logic [31:0]       q_reg;
    logic [3:0]        rem_reg;
    logic [4:0]        step_reg;
    logic [1:0]        pend_kind_reg;
    logic [IDXW-1:0]   pend_index_reg;
    logic [31:0]       pend_hits_reg;
    logic              pend_status_reg;
    logic              pend_last_reg;
    logic [31:0]       frame_reg;

    logic [1:0]        out_kind_reg;
    logic [31:0]       out_frame_reg;
    logic [2:0]        out_index_reg;
    logic [31:0]       out_cycles_reg;
    logic [31:0]       out_hits_reg;
    logic              out_status_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    logic [3:0]        dvs;
    logic [4:0]        trial;
    logic              out_free;
    logic [IDXW-1:0]   next_idx;

    assign dvs = (divider_reg == 4'd0) ? abcp_pkg::DEFAULT_DIVIDER : divider_reg;
    assign trial = {rem_reg, q_reg[31]};
    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign next_idx = (pend_kind_reg == abcp_pkg::KIND_TOTAL) ? '0 : pend_index_reg + 1'b1;

    assign out_valid = out_valid_reg;
    assign record_kind = out_kind_reg;
    assign frame_out = out_frame_reg;
    assign bracket_index = out_index_reg;
    assign cpu_cycles = out_cycles_reg;
    assign hit_count = out_hits_reg;
    assign status = out_status_reg;
    assign last = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            case (q_item.op)
                abcp_pkg::OP_PC:
                begin
                    for (int i = 0; i < MAX_BRACKETS; i++)
                    begin
                        if (CW'(i) < count_reg && q_item.pc == entry_addr_reg[i])
                        begin
                            entry_cycle_reg[i] <= q_item.cycle;
                        end
                    end
                end
                abcp_pkg::OP_REBASE:
                begin
                    for (int i = 0; i < MAX_BRACKETS; i++)
                    begin
                        if (CW'(i) < count_reg && active_reg[i])
                        begin
                            entry_cycle_reg[i] <= entry_cycle_reg[i] - q_item.deduct;
                        end
                    end
                end
                abcp_pkg::OP_ADD:
                begin
                    if (count_reg < CW'(MAX_BRACKETS))
                    begin
                        entry_addr_reg[count_reg[IDXW-1:0]] <= q_item.saddr;
                        exit_addr_reg[count_reg[IDXW-1:0]] <= q_item.eaddr;
                        entry_cycle_reg[count_reg[IDXW-1:0]] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < MAX_BRACKETS; i++)
            begin
                accum_reg[i] <= '0;
                hits_reg[i] <= '0;
            end
            active_reg <= '0;
            count_reg <= '0;
            anchor_reg <= '0;
            anchor_valid_reg <= 1'b0;
            prev_frame_reg <= abcp_pkg::FRAME_NONE;
            divider_reg <= abcp_pkg::RESET_DIVIDER;
            log_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            q_reg <= '0;
            rem_reg <= '0;
            step_reg <= '0;
            pend_kind_reg <= abcp_pkg::KIND_ADD;
            pend_index_reg <= '0;
            pend_hits_reg <= '0;
            pend_status_reg <= 1'b0;
            pend_last_reg <= 1'b0;
            frame_reg <= '0;
            out_kind_reg <= abcp_pkg::KIND_ADD;
            out_frame_reg <= '0;
            out_index_reg <= '0;
            out_cycles_reg <= '0;
            out_hits_reg <= '0;
            out_status_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == abcp_pkg::CFG_DIVIDER)
                begin
                    divider_reg <= cfg_data;
                end
                else if (cfg_index == abcp_pkg::CFG_LOG)
                begin
                    log_reg <= cfg_data[0];
                end
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        case (q_item.op)
                            abcp_pkg::OP_PC:
                            begin
                                for (int i = 0; i < MAX_BRACKETS; i++)
                                begin
                                    if (CW'(i) < count_reg)
                                    begin
                                        if (q_item.pc == entry_addr_reg[i])
                                        begin
                                            active_reg[i] <= 1'b1;
                                        end
                                        else if (q_item.pc == exit_addr_reg[i] && active_reg[i])
                                        begin
                                            accum_reg[i] <= accum_reg[i]
                                                + (q_item.cycle - entry_cycle_reg[i]);
                                            hits_reg[i] <= hits_reg[i] + 32'd1;
                                            active_reg[i] <= 1'b0;
                                        end
                                    end
                                end
                            end
                            abcp_pkg::OP_FRAME:
                            begin
                                if (q_item.frame != prev_frame_reg)
                                begin
                                    prev_frame_reg <= q_item.frame;
                                    if (log_reg || count_reg != '0)
                                    begin
                                        anchor_reg <= q_item.cycle;
                                        anchor_valid_reg <= 1'b1;
                                        if (log_reg)
                                        begin
                                            q_reg <= anchor_valid_reg
                                                ? q_item.cycle - anchor_reg : '0;
                                            rem_reg <= '0;
                                            step_reg <= '0;
                                            frame_reg <= q_item.frame;
                                            pend_kind_reg <= abcp_pkg::KIND_TOTAL;
                                            pend_index_reg <= '0;
                                            pend_hits_reg <= '0;
                                            pend_status_reg <= 1'b0;
                                            pend_last_reg <= (count_reg == '0);
                                            state_reg <= S_DIV;
                                        end
                                        else
                                        begin
                                            for (int i = 0; i < MAX_BRACKETS; i++)
                                            begin
                                                accum_reg[i] <= '0;
                                                hits_reg[i] <= '0;
                                            end
                                        end
                                    end
                                end
                            end
                            abcp_pkg::OP_REBASE:
                            begin
                                if (anchor_valid_reg)
                                begin
                                    anchor_reg <= anchor_reg - q_item.deduct;
                                end
                            end
                            abcp_pkg::OP_ADD:
                            begin
                                q_reg <= '0;
                                frame_reg <= '0;
                                pend_kind_reg <= abcp_pkg::KIND_ADD;
                                pend_hits_reg <= '0;
                                pend_last_reg <= 1'b1;
                                if (count_reg < CW'(MAX_BRACKETS))
                                begin
                                    accum_reg[count_reg[IDXW-1:0]] <= '0;
                                    hits_reg[count_reg[IDXW-1:0]] <= '0;
                                    active_reg[count_reg[IDXW-1:0]] <= 1'b0;
                                    count_reg <= count_reg + 1'b1;
                                    pend_index_reg <= count_reg[IDXW-1:0];
                                    pend_status_reg <= 1'b0;
                                end
                                else
                                begin
                                    pend_index_reg <= '0;
                                    pend_status_reg <= 1'b1;
                                end
                                state_reg <= S_OUT;
                            end
                            abcp_pkg::OP_CLEAR:
                            begin
                                for (int i = 0; i < MAX_BRACKETS; i++)
                                begin
                                    accum_reg[i] <= '0;
                                    hits_reg[i] <= '0;
                                end
                                active_reg <= '0;
                                count_reg <= '0;
                                anchor_valid_reg <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (trial >= {1'b0, dvs})
                    begin
                        rem_reg <= 4'(trial - {1'b0, dvs});
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[3:0];
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg <= pend_kind_reg;
                        out_frame_reg <= frame_reg;
                        out_index_reg <= 3'(pend_index_reg);
                        out_cycles_reg <= q_reg;
                        out_hits_reg <= pend_hits_reg;
                        out_status_reg <= pend_status_reg;
                        out_last_reg <= pend_last_reg;
                        if (pend_kind_reg == abcp_pkg::KIND_ADD)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (pend_last_reg)
                        begin
                            for (int i = 0; i < MAX_BRACKETS; i++)
                            begin
                                accum_reg[i] <= '0;
                                hits_reg[i] <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            q_reg <= accum_reg[next_idx];
                            rem_reg <= '0;
                            step_reg <= '0;
                            pend_kind_reg <= abcp_pkg::KIND_BRACKET;
                            pend_index_reg <= next_idx;
                            pend_hits_reg <= hits_reg[next_idx];
                            pend_last_reg <= (CW'(next_idx) + 1'b1 == count_reg);
                            state_reg <= S_DIV;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_CHK(a_state_onehot, clk, rst_n, $onehot(state_reg), "sequencer state not one-hot")
    `ASSERT_CHK(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_BRACKETS),
        "bracket count beyond table size")
    `ASSERT_NEXT(a_div_exit, clk, rst_n, state_reg == S_DIV && step_reg == 5'd31,
        state_reg == S_OUT, "divider did not hand over its quotient")

endmodule

### hdl/address_bracket_cycle_profiler_core.sv
// Address bracket cycle profiler.
// Input channel (in_valid/in_stall) takes one request per transfer: pc event,
// frame boundary, rebase, add bracket or clear. Unknown request types are dropped.
// Output channel (out_valid/out_stall) carries result records; the last one of
// a request has last set. Configuration writes (cfg_valid/cfg_ready) are always
// taken: index 0 is the clock divider, index 1 enables logging.
// A two-entry queue parts the input stage from the execution sequencer.
// Pc events, rebase and clear are carried out as the sequencer pops them; add
// bracket then passes to the output state, which registers its status record.
// A logged frame event emits one record for the frame total and one per bracket,
// each set by the one-bit-per-cycle divider that scales cycle counts.
// While out_stall is high, the finished record holds and the sequencer waits to
// emit the next; the input side keeps taking requests until the queue is full.
// Reset clears all brackets, the frame anchor and the queue, sets the divider
// to 7, logging off and the last frame number to all ones.
module address_bracket_cycle_profiler_core
#(
    parameter int MAX_BRACKETS = abcp_pkg::MAX_BRACKETS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [23:0] pc,
    input  logic [31:0] cycle,
    input  logic [31:0] frame_number,
    input  logic [23:0] start_address,
    input  logic [23:0] end_address,
    input  logic [31:0] deduction,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [31:0] frame_out,
    output logic [2:0]  bracket_index,
    output logic [31:0] cpu_cycles,
    output logic [31:0] hit_count,
    output logic        status,
    output logic        last
);

    logic            q_valid;
    logic            q_pop;
    abcp_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    abcp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .pc            (pc),
        .cycle         (cycle),
        .frame_number  (frame_number),
        .start_address (start_address),
        .end_address   (end_address),
        .deduction     (deduction),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    abcp_back #(.MAX_BRACKETS(MAX_BRACKETS)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_kind   (record_kind),
        .frame_out     (frame_out),
        .bracket_index (bracket_index),
        .cpu_cycles    (cpu_cycles),
        .hit_count     (hit_count),
        .status        (status),
        .last          (last)
    );

endmodule
